// ----- rtl/core/htp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htp_pkg;

	// Field widths of the stream payloads.
	localparam int KEY_W      = 64;
	localparam int VALUE_W    = 64;
	localparam int PART_W     = 6;
	localparam int SLOT_W     = 10;
	localparam int ADDR_W     = 16;
	localparam int IN_DATA_W  = KEY_W + VALUE_W;
	localparam int OUT_DATA_W = PART_W + SLOT_W + ADDR_W + KEY_W + VALUE_W;
	localparam int OUT_USER_W = 2;

	// Configuration port.
	localparam int CFG_W      = 11;
	localparam int CNT_CFG_W  = 7;
	localparam int CAP_CFG_W  = 11;
	localparam logic REG_PARTITION_COUNT    = 1'b0;
	localparam logic REG_PARTITION_CAPACITY = 1'b1;
	localparam logic [CNT_CFG_W-1:0] COUNT_RESET    = 7'd16;
	localparam logic [CAP_CFG_W-1:0] CAPACITY_RESET = 11'd1024;

	// Key bits consumed by the remainder unit per cycle.
	localparam int DIV_BITS = 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input beat
		logic step;   // one remainder iteration
		logic read;   // read the fill counter of the partition
		logic calc;   // compare, multiply, update the counter
		logic emit;   // load the output register
	} htp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_clear;  // mode bit of the offered input beat
		logic out_free;  // output register can take a result
	} htp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/htp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htp_ctrl import htp_pkg::*; #(
	parameter int KEY_WIDTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  htp_status_t status,
	output htp_cmd_t    cmd
);

	localparam int KEY_STEPS = (KEY_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int SCW       = $clog2(KEY_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic [SCW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						state_q <= status.in_clear ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == SCW'(KEY_STEPS - 1)) begin
						state_q <= ST_READ;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && s_tvalid;
		cmd.step = (state_q == ST_DIV);
		cmd.read = (state_q == ST_READ);
		cmd.calc = (state_q == ST_CALC);
		cmd.emit = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

`default_nettype wire

// ----- rtl/core/htp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htp_datapath import htp_pkg::*; #(
	parameter int MAX_PARTITIONS      = 64,
	parameter int SLOTS_PER_PARTITION = 1024,
	parameter int KEY_WIDTH           = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [IN_DATA_W-1:0]  s_tdata,
	input  wire                   s_tuser,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,
	input  wire                   cfg_we,
	input  wire                   cfg_addr,
	input  wire  [CFG_W-1:0]      cfg_wdata,
	input  htp_cmd_t              cmd,
	output htp_status_t           status
);

	localparam int DW        = $clog2(MAX_PARTITIONS + 1);
	localparam int PW        = $clog2(MAX_PARTITIONS);
	localparam int CNTW      = $clog2(SLOTS_PER_PARTITION + 1);
	localparam int AW        = PW + CNTW;
	localparam int KEY_STEPS = (KEY_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int KEY_PAD   = KEY_STEPS * DIV_BITS;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_WIDTH);

	// Configuration registers.
	logic [CNT_CFG_W-1:0] count_q;
	logic [CAP_CFG_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			cap_q   <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PARTITION_COUNT:    count_q <= cfg_wdata[CNT_CFG_W-1:0];
				REG_PARTITION_CAPACITY: cap_q   <= cfg_wdata[CAP_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated divisor and capacity.
	logic [DW-1:0]   eff_cnt;
	logic [CNTW-1:0] eff_cap;

	always_comb begin
		if (count_q == '0) begin
			eff_cnt = DW'(1);
		end else if (32'(count_q) > MAX_PARTITIONS) begin
			eff_cnt = DW'(MAX_PARTITIONS);
		end else begin
			eff_cnt = DW'(count_q);
		end
		if (32'(cap_q) > SLOTS_PER_PARTITION) begin
			eff_cap = CNTW'(SLOTS_PER_PARTITION);
		end else begin
			eff_cap = CNTW'(cap_q);
		end
	end

	// Input capture.
	logic               mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [KEY_PAD-1:0] key_sr_q;
	logic [PW-1:0]      rem_q;
	logic [PW-1:0]      rem_next;

	// Restoring remainder, DIV_BITS key bits per step, most significant first.
	always_comb begin
		logic [PW:0] trial;
		logic [PW:0] dvs;
		rem_next = rem_q;
		dvs      = (PW + 1)'(eff_cnt);
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_next, key_sr_q[KEY_PAD-1-i]};
			if (trial >= dvs) begin
				trial = trial - dvs;
			end
			rem_next = trial[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= s_tuser;
			key_q    <= s_tdata[KEY_W-1:0] & KEY_MASK;
			value_q  <= s_tdata[IN_DATA_W-1:KEY_W];
			key_sr_q <= KEY_PAD'(s_tdata[KEY_W-1:0] & KEY_MASK);
			rem_q    <= '0;
		end else if (cmd.step) begin
			key_sr_q <= key_sr_q << DIV_BITS;
			rem_q    <= rem_next;
		end
	end

	// Fill counters: memory plus per-entry valid bits cleared at once.
	logic [CNTW-1:0]           fill_mem [MAX_PARTITIONS];
	logic [MAX_PARTITIONS-1:0] fill_vld_q;
	logic [CNTW-1:0]           rd_fill_q;
	logic                      rd_vld_q;
	logic [CNTW-1:0]           fill_cur;
	logic                      full_cur;

	assign fill_cur = rd_vld_q ? rd_fill_q : '0;
	assign full_cur = (fill_cur >= eff_cap);

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_fill_q <= fill_mem[rem_q];
		end
		if (cmd.calc && !full_cur) begin
			fill_mem[rem_q] <= fill_cur + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (cmd.load && s_tuser) begin
				fill_vld_q <= '0;
			end else if (cmd.calc && !full_cur) begin
				fill_vld_q[rem_q] <= 1'b1;
			end
			if (cmd.read) begin
				rd_vld_q <= fill_vld_q[rem_q];
			end
		end
	end

	// Address product, registered before the final add.
	logic [AW-1:0]   prod_q;
	logic [CNTW-1:0] fill_q;
	logic            full_q;
	logic [AW-1:0]   addr_sum;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			prod_q <= AW'(rem_q) * AW'(eff_cap);
			fill_q <= fill_cur;
			full_q <= full_cur;
		end
	end

	assign addr_sum = prod_q + AW'(fill_q);

	// Output register.
	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (mode_q) begin
				out_data_q <= '0;
				out_user_q <= '0;
			end else if (full_q) begin
				out_data_q <= {value_q, key_q, ADDR_W'(0), SLOT_W'(0), PART_W'(rem_q)};
				out_user_q <= 2'b01;
			end else begin
				out_data_q <= {value_q, key_q, ADDR_W'(addr_sum), SLOT_W'(fill_q),
					PART_W'(rem_q)};
				out_user_q <= 2'b10;
			end
		end
	end

	assign m_tvalid        = out_vld_q;
	assign m_tdata         = out_data_q;
	assign m_tuser         = out_user_q;
	assign status.in_clear = s_tuser;
	assign status.out_free = !out_vld_q || m_tready;

endmodule

`default_nettype wire

// ----- rtl/core/hash_tuple_partitioner.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// s_*       in         tdata: tuple_key, tuple_value; tuser: mode
// m_*       out        tdata: part/slot/address/key/value; tuser: overflow, write_valid
// cfg_*     in         one register write per cycle with cfg_we high
//
// A routed tuple runs the remainder steps, in which the shared remainder unit
// retires eight key bits a cycle, then reads the fill counter, multiplies and
// updates, and loads the output register before the next beat is accepted.
// A clear beat goes straight to the output load.
// Reset clears the control state and all counter valid bits at once.
// A stalled output holds the result in its register; the next beat is still
// accepted and worked on, and waits only at the final load.
module hash_tuple_partitioner import htp_pkg::*; #(
	parameter int MAX_PARTITIONS      = 64,
	parameter int SLOTS_PER_PARTITION = 1024,
	parameter int KEY_WIDTH           = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// Input tuples.
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [IN_DATA_W-1:0]  s_tdata,   // tuple_key[63:0], tuple_value[127:64]
	input  wire                   s_tuser,   // mode: 0 route, 1 clear all counters
	// Routing results.
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // part_index[5:0], slot_index[15:6],
	                                         // write_address[31:16], out_key[95:32],
	                                         // out_value[159:96]
	output logic [OUT_USER_W-1:0] m_tuser,   // overflow[0], write_valid[1]
	// Configuration writes.
	input  wire                   cfg_we,
	input  wire                   cfg_addr,
	input  wire  [CFG_W-1:0]      cfg_wdata
);

	htp_cmd_t    cmd;
	htp_status_t status;

	// The controller sequences remainder steps, the counter read, the update and
	// the output load; the datapath owns every register that carries data.
	htp_ctrl #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	htp_datapath #(
		.MAX_PARTITIONS      (MAX_PARTITIONS),
		.SLOTS_PER_PARTITION (SLOTS_PER_PARTITION),
		.KEY_WIDTH           (KEY_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

// ----- test/htp_route_checker.sv -----
`timescale 1ns / 1ps

// Watches the tuple, result and configuration channels of the partitioner,
// predicts each routing result and compares it field by field.
module htp_route_checker import htp_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	input  wire                   s_tready,
	input  wire  [IN_DATA_W-1:0]  s_tdata,   // tuple_key[63:0], tuple_value[127:64]
	input  wire                   s_tuser,   // mode
	input  wire                   m_tvalid,
	input  wire                   m_tready,
	input  wire  [OUT_DATA_W-1:0] m_tdata,   // part_index, slot_index, write_address,
	                                         // out_key, out_value
	input  wire  [OUT_USER_W-1:0] m_tuser,   // overflow, write_valid
	input  wire                   cfg_we,
	input  wire                   cfg_addr,
	input  wire  [CFG_W-1:0]      cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int MAX_PARTS = 64;
	localparam int MAX_SLOTS = 1024;

	typedef struct packed {
		logic [PART_W-1:0]  part;
		logic [SLOT_W-1:0]  slot;
		logic [ADDR_W-1:0]  addr;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic               overflow;
		logic               write_valid;
	} route_t;

	logic [CNT_CFG_W-1:0] count_reg;
	logic [CAP_CFG_W-1:0] cap_reg;
	logic [10:0]          fill_level [MAX_PARTS];
	route_t               expected_routes [$];
	route_t               got, want;
	int                   errors;

	// Works out the result of one beat and advances or clears the fill levels.
	function automatic route_t route_tuple(logic mode, logic [KEY_W-1:0] key,
	                                       logic [VALUE_W-1:0] value);
		route_t      r;
		int unsigned divisor;
		int unsigned limit;
		logic [5:0]  part;
		logic [10:0] level;
		r = '0;
		if (mode) begin
			foreach (fill_level[i]) fill_level[i] = '0;
			return r;
		end
		divisor = (count_reg == 0) ? 1 : ((count_reg > MAX_PARTS) ? MAX_PARTS : count_reg);
		limit   = (cap_reg > MAX_SLOTS) ? MAX_SLOTS : cap_reg;
		part    = 6'(key % 64'(divisor));
		level   = fill_level[part];
		r.part  = part;
		r.key   = key;
		r.value = value;
		if (level >= limit) begin
			r.overflow = 1'b1;
		end else begin
			r.slot        = level[SLOT_W-1:0];
			r.addr        = 16'(part * limit + level);
			r.write_valid = 1'b1;
			fill_level[part] = level + 11'd1;
		end
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
		if (errors < 10)
			$display("mismatch %s: expected %h, got %h at %0t", field, exp_val, act_val, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = COUNT_RESET;
			cap_reg   = CAPACITY_RESET;
			foreach (fill_level[i]) fill_level[i] = '0;
			expected_routes.delete();
			errors = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// A result leaves before a new beat is logged: it can never belong
			// to a beat accepted on the same edge.
			if (m_tvalid && m_tready) begin
				got = {m_tdata[5:0], m_tdata[15:6], m_tdata[31:16], m_tdata[95:32],
				       m_tdata[159:96], m_tuser[0], m_tuser[1]};
				if (expected_routes.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %h at %0t", m_tdata, $time);
					errors++;
				end else begin
					want = expected_routes.pop_front();
					if (got.part != want.part)
						note_mismatch("part_index", 64'(want.part), 64'(got.part));
					if (got.slot != want.slot)
						note_mismatch("slot_index", 64'(want.slot), 64'(got.slot));
					if (got.addr != want.addr)
						note_mismatch("write_address", 64'(want.addr), 64'(got.addr));
					if (got.key != want.key)
						note_mismatch("out_key", want.key, got.key);
					if (got.value != want.value)
						note_mismatch("out_value", want.value, got.value);
					if (got.overflow != want.overflow)
						note_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
					if (got.write_valid != want.write_valid)
						note_mismatch("write_valid", 64'(want.write_valid),
						              64'(got.write_valid));
				end
			end
			if (s_tvalid && s_tready)
				expected_routes.push_back(route_tuple(s_tuser, s_tdata[KEY_W-1:0],
				                                      s_tdata[IN_DATA_W-1:KEY_W]));
			if (cfg_we) begin
				if (cfg_addr == REG_PARTITION_COUNT)
					count_reg = cfg_wdata[CNT_CFG_W-1:0];
				else
					cap_reg = cfg_wdata[CAP_CFG_W-1:0];
			end
			fail_count <= errors;
			pending    <= expected_routes.size();
		end
	end

endmodule

// ----- test/hash_tuple_partitioner_tb.sv -----
`timescale 1ns / 1ps

// Drives tuple beats and register writes into the partitioner and gives the
// verdict. All prediction and comparison lives in the checker instance.
module hash_tuple_partitioner_tb;
	import htp_pkg::*;

	// Longest run of cycles without any beat on either channel. The slowest
	// correct case is the longest sender gap, the longest receiver stall and
	// one routed tuple; this is many times that.
	localparam int STALL_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // tuple_key[63:0], tuple_value[127:64]
	logic                  s_tuser   = 1'b0; // mode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // part_index[5:0], slot_index[15:6],
	                                         // write_address[31:16], out_key[95:32],
	                                         // out_value[159:96]
	logic [OUT_USER_W-1:0] m_tuser;          // overflow[0], write_valid[1]
	logic                  cfg_we    = 1'b0;
	logic                  cfg_addr  = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit steady_in   = 1'b0;
	int cur_count   = 16;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	hash_tuple_partitioner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	htp_route_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Keys are a mix of wide random words, small numbers, the extremes and
	// values right around a multiple of the partition count, where the
	// remainder wraps.
	function automatic logic [63:0] pick_key(int count);
		int          r;
		int unsigned divisor;
		logic [63:0] k;
		divisor = (count == 0) ? 1 : ((count > 64) ? 64 : count);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			k = {$urandom, $urandom};
		end else if (r < 60) begin
			k = 64'($urandom_range(0, 255));
		end else if (r < 75) begin
			case ($urandom_range(0, 3))
				0:       k = '0;
				1:       k = '1;
				2:       k = 64'h8000_0000_0000_0000;
				default: k = 64'h7FFF_FFFF_FFFF_FFFF;
			endcase
		end else begin
			k = {$urandom, $urandom} / 64'(divisor) * 64'(divisor);
			k = k + 64'($urandom_range(0, 1)) - 64'($urandom_range(0, 1));
		end
		return k;
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offers one beat and returns on the edge that accepts it. The valid
	// stays high afterwards so back-to-back beats need no extra assignment.
	task automatic send_beat(logic mode, logic [63:0] key, logic [63:0] value);
		int gap;
		gap = steady_in ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {value, key};
		do @(posedge clk); while (!s_tready);
	endtask

	// Holds the sender off until every outstanding result has arrived. The
	// first edge is taken before looking, since the pending count is registered
	// and trails the last accepted beat.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; the block is idle here.
	task automatic write_config(int count, int cap);
		cur_count = count;
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_PARTITION_COUNT;
		cfg_wdata <= CFG_W'(count);
		@(posedge clk);
		cfg_addr  <= REG_PARTITION_CAPACITY;
		cfg_wdata <= CFG_W'(cap);
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int count, int cap, int items, int clear_pct);
		logic mode;
		wait_results();
		write_config(count, cap);
		steady_in = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < items; i++) begin
			mode = ($urandom_range(0, 99) < clear_pct);
			send_beat(mode, pick_key(cur_count), pick_value());
			// Now and then the sender holds off mid-phase until all is out.
			if ($urandom_range(0, 99) == 0)
				wait_results();
		end
	endtask

	// Result side: random stalls, mostly short, with long ready stretches too.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// The run ends here if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings (16 partitions, 1024 slots):
		// the key extremes, two keys in one partition, and a clear beat with
		// a busy payload, which must give an all-zero result.
		send_beat(1'b0, 64'h0, 64'h0);
		send_beat(1'b0, '1, '1);
		send_beat(1'b0, 64'd16, 64'h0123_4567_89AB_CDEF);
		send_beat(1'b0, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
		send_beat(1'b0, 64'd15, 64'hAAAA_AAAA_AAAA_AAAA);
		send_beat(1'b1, '1, '1);
		send_beat(1'b0, 64'h0, 64'hFEED_FACE_CAFE_BEEF);

		// One partition of two slots: fill it, overflow it, clear, reuse.
		wait_results();
		write_config(1, 2);
		send_beat(1'b0, 64'd5, pick_value());
		send_beat(1'b0, 64'd9, pick_value());
		send_beat(1'b0, 64'd7, pick_value());
		send_beat(1'b1, 64'd0, 64'd0);
		send_beat(1'b0, 64'd3, pick_value());

		// A zero partition count acts as one; zero capacity makes every tuple
		// overflow.
		wait_results();
		write_config(0, 0);
		send_beat(1'b0, 64'd123, pick_value());
		send_beat(1'b0, '1, '1);

		// Out-of-range settings saturate to 64 partitions and 1024 slots.
		wait_results();
		write_config(127, 2047);
		send_beat(1'b0, '1, pick_value());
		send_beat(1'b0, 64'd63, pick_value());
		send_beat(1'b0, 64'd64, pick_value());
		send_beat(1'b0, 64'd127, pick_value());

		// Random part: small capacities so partitions fill and overflow often,
		// the range extremes, and one long stretch with two deep partitions.
		run_phase(1, 1, 30, 10);
		run_phase(0, 5, 60, 5);
		run_phase(127, 2047, 80, 2);
		run_phase(64, 1024, 80, 2);
		run_phase(3, 0, 40, 5);
		run_phase(7, 37, 200, 2);
		run_phase(2, 200, 300, 1);
		repeat (4)
			run_phase($urandom_range(1, 64), $urandom_range(1, 64), 60, 3);

		wait_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
